// File: sv/kct_pkg.sv
// kct_pkg: shared types and constants for the keyframe curve table
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package kct_pkg;
  localparam int MaxKeys = 16;
  localparam int IdxW = $clog2(MaxKeys);
  localparam int CntW = $clog2(MaxKeys + 1);

  typedef enum logic [2:0] {
    OP_EVAL   = 3'd0,
    OP_ADD    = 3'd1,
    OP_REMOVE = 3'd2,
    OP_SETVAL = 3'd3,
    OP_READ   = 3'd4,
    OP_CLEAR  = 3'd5,
    OP_SINGLE = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_TIME  = 2'd1,
    ST_INDEX = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_MAX_TIME      = 2'd0,
    CFG_REPEAT_TIME   = 2'd1,
    CFG_VALUE_SCALE   = 2'd2,
    CFG_DEFAULT_VALUE = 2'd3
  } cfg_idx_t;

  // request to the shared arithmetic unit
  typedef struct packed {
    logic        mul;
    logic        div;
    logic [63:0] a;
    logic [63:0] b;
  } alu_req_t;

  // res is the product or the quotient, rem the remainder of a divide
  typedef struct packed {
    logic        done;
    logic [63:0] res;
    logic [63:0] rem;
  } alu_rsp_t;
endpackage
`default_nettype wire

// File: sv/kct_alu.sv
// kct_alu: shared multi-cycle unit, shift-add multiply and restoring divide
// depends on kct_pkg
`timescale 1ns / 1ps
`default_nettype none
module kct_alu (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  kct_pkg::alu_req_t      req,
  output kct_pkg::alu_rsp_t      rsp
);
  import kct_pkg::*;

  logic        busy_r, busy_nxt;
  logic        is_div_r, is_div_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] a_r, a_nxt;
  logic [63:0] b_r, b_nxt;
  logic        done_r, done_nxt;
  logic [64:0] rem_sh;

  // one bit per cycle: multiply a 64-bit operand by the low 32 bits of b, divide 64 by 64
  always_comb begin
    busy_nxt = busy_r;
    is_div_nxt = is_div_r;
    cnt_nxt = cnt_r;
    acc_nxt = acc_r;
    a_nxt = a_r;
    b_nxt = b_r;
    done_nxt = 1'b0;
    rem_sh = {acc_r, a_r[63]};
    if (!busy_r) begin
      if (req.mul || req.div) begin
        busy_nxt = 1'b1;
        is_div_nxt = req.div;
        a_nxt = req.a;
        b_nxt = req.b;
        acc_nxt = '0;
        cnt_nxt = req.div ? 6'd63 : 6'd31;
      end
    end else if (!is_div_r) begin
      if (b_r[0]) acc_nxt = acc_r + a_r;
      a_nxt = a_r << 1;
      b_nxt = b_r >> 1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else cnt_nxt = cnt_r - 6'd1;
    end else begin
      // acc is remainder, a shifts into quotient
      if (rem_sh >= {1'b0, b_r}) begin
        acc_nxt = 64'(rem_sh - {1'b0, b_r});
        a_nxt = {a_r[62:0], 1'b1};
      end else begin
        acc_nxt = rem_sh[63:0];
        a_nxt = {a_r[62:0], 1'b0};
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else cnt_nxt = cnt_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    is_div_r <= is_div_nxt;
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    a_r <= a_nxt;
    b_r <= b_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.res = is_div_r ? a_r : acc_r;
  assign rsp.rem = acc_r;
endmodule
`default_nettype wire

// File: sv/keyframe_curve_table_core.sv
// keyframe_curve_table_core: sorted key table with interpolated evaluation
// depends on kct_pkg and kct_alu
//
//  channel | direction | handshake      | payload
//  in_     | input     | valid / stall  | operation, time_req, value, index
//  out_    | output    | valid / stall  | curve_value, key_time_out, ...
//  cfg_    | input     | valid / ready  | index, data
//
// one item at a time; table ops move or scan the keys one at a time, and
// evaluate runs the bit-serial multiply (up to three of them) and divide
// (up to two of them) of the shared unit plus a scan of the held keys.
// synchronous active-low reset leaves one key at time 0, value 65536.
// a held result stalls the next accept and any config write.
`timescale 1ns / 1ps
`default_nettype none
module keyframe_curve_table_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_operation,
  input  wire logic [31:0] in_time_req,
  input  wire logic signed [31:0] in_value,
  input  wire logic [3:0]  in_index,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [31:0] out_curve_value,
  output logic [31:0]      out_key_time_out,
  output logic signed [31:0] out_key_value_out,
  output logic [3:0]       out_key_position,
  output logic [4:0]       out_key_count,
  output logic [1:0]       out_status,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import kct_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SHIFT_UP, S_SHIFT_DN, S_EV_MUL, S_EV_MOD, S_EV_FIND,
    S_EV_MUL2, S_EV_DIV, S_SCALE, S_SCALE_W, S_OUT
  } state_t;

  state_t state_r;
  logic [31:0] max_time_r, repeat_time_r, value_scale_r;
  logic signed [31:0] default_value_r;
  logic [31:0] times_r [MaxKeys];
  logic signed [31:0] vals_r [MaxKeys];
  logic [CntW-1:0] held_r;
  logic [31:0] treq_r, t_r;
  logic signed [31:0] val_r;
  logic [IdxW-1:0] j_r;
  logic [CntW-1:0] i_r;
  logic signed [32:0] d_r;
  logic signed [32:0] v1_r;
  logic signed [31:0] sv_r;
  logic [31:0] den_r;
  alu_req_t areq;
  alu_rsp_t arsp;
  logic signed [31:0] o_curve_r, o_kval_r;
  logic [31:0] o_ktime_r;
  logic [3:0]  o_pos_r;
  logic [1:0]  o_stat_r;
  logic        go_mul_r, go_div_r;
  logic [63:0] ga_r, gb_r;

  logic [IdxW-1:0] last;
  logic [IdxW-1:0] ii;
  logic [32:0] mag33;
  logic [63:0] q64;
  logic        idx_ok;
  logic signed [32:0] dif;
  logic [31:0] dif_mag;

  assign last = IdxW'(held_r - CntW'(1));
  assign ii = i_r[IdxW-1:0];
  assign idx_ok = ({1'b0, in_index} < held_r);
  assign in_stall = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_curve_value = o_curve_r;
  assign out_key_time_out = o_ktime_r;
  assign out_key_value_out = o_kval_r;
  assign out_key_position = o_pos_r;
  assign out_key_count = held_r;
  assign out_status = o_stat_r;

  assign areq.mul = go_mul_r;
  assign areq.div = go_div_r;
  assign areq.a = ga_r;
  assign areq.b = gb_r;

  kct_alu u_alu (.clk(clk), .rst_n(rst_n), .req(areq), .rsp(arsp));

  assign mag33 = sv_r[31] ? 33'(-$signed({sv_r[31], sv_r})) : {1'b0, sv_r};
  assign q64 = arsp.res >> 16;

  // value step between the bracketing keys and its magnitude
  assign dif = 33'(vals_r[ii]) - 33'(vals_r[ii - IdxW'(1)]);
  assign dif_mag = dif[32] ? 32'(-dif) : dif[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      go_mul_r <= 1'b0;
      go_div_r <= 1'b0;
      max_time_r <= 32'd65536;
      repeat_time_r <= 32'd65536;
      value_scale_r <= 32'd65536;
      default_value_r <= 32'sd65536;
      held_r <= CntW'(1);
      times_r[0] <= '0;
      vals_r[0] <= 32'sd65536;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_MAX_TIME:      max_time_r <= cfg_data;
          CFG_REPEAT_TIME:   repeat_time_r <= cfg_data;
          CFG_VALUE_SCALE:   value_scale_r <= cfg_data;
          CFG_DEFAULT_VALUE: default_value_r <= cfg_data;
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: if (in_valid) begin
          treq_r <= in_time_req;
          val_r <= in_value;
          o_curve_r <= '0;
          o_pos_r <= '0;
          i_r <= '0;
          o_ktime_r <= (op_t'(in_operation) == OP_READ && idx_ok) ? times_r[in_index] : '0;
          o_kval_r <= (op_t'(in_operation) == OP_READ && idx_ok) ? vals_r[in_index] : '0;
          case (op_t'(in_operation))
            OP_EVAL: begin
              o_stat_r <= ST_OK;
              if (in_time_req == '0 || held_r < CntW'(2)) begin
                sv_r <= vals_r[0];
                state_r <= S_SCALE;
              end else begin
                ga_r <= {32'd0, (in_time_req < max_time_r) ? in_time_req : max_time_r};
                gb_r <= {32'd0, repeat_time_r};
                go_mul_r <= 1'b1;
                state_r <= S_EV_MUL;
              end
            end
            OP_ADD: begin
              if (in_time_req > max_time_r) begin
                o_stat_r <= ST_TIME;
                state_r <= S_OUT;
              end else begin
                o_stat_r <= ST_OK;
                state_r <= S_SCAN;
              end
            end
            OP_REMOVE: begin
              if (in_index == '0 || !idx_ok) begin
                o_stat_r <= ST_INDEX;
                state_r <= S_OUT;
              end else begin
                o_stat_r <= ST_OK;
                j_r <= in_index;
                state_r <= S_SHIFT_DN;
              end
            end
            OP_SETVAL: begin
              state_r <= S_OUT;
              if (!idx_ok) o_stat_r <= ST_INDEX;
              else begin
                o_stat_r <= ST_OK;
                vals_r[in_index] <= in_value;
              end
            end
            OP_READ: begin
              state_r <= S_OUT;
              o_stat_r <= idx_ok ? ST_OK : ST_INDEX;
            end
            OP_CLEAR, OP_SINGLE: begin
              state_r <= S_OUT;
              o_stat_r <= ST_OK;
              times_r[0] <= '0;
              vals_r[0] <= (op_t'(in_operation) == OP_CLEAR) ? default_value_r : in_value;
              held_r <= CntW'(1);
            end
            default: begin
              state_r <= S_OUT;
              o_stat_r <= ST_OK;
            end
          endcase
        end
        // find first key with time >= request
        S_SCAN: begin
          if (i_r < held_r && times_r[ii] < treq_r) i_r <= i_r + CntW'(1);
          else if (i_r < held_r && times_r[ii] == treq_r) begin
            vals_r[ii] <= val_r;
            o_pos_r <= 4'(i_r);
            state_r <= S_OUT;
          end else if (held_r >= CntW'(MaxKeys)) begin
            o_stat_r <= ST_FULL;
            state_r <= S_OUT;
          end else begin
            j_r <= IdxW'(held_r);
            state_r <= S_SHIFT_UP;
          end
        end
        S_SHIFT_UP: begin
          if ({1'b0, j_r} > i_r) begin
            times_r[j_r] <= times_r[j_r - IdxW'(1)];
            vals_r[j_r] <= vals_r[j_r - IdxW'(1)];
            j_r <= j_r - IdxW'(1);
          end else begin
            times_r[ii] <= treq_r;
            vals_r[ii] <= val_r;
            held_r <= held_r + CntW'(1);
            o_pos_r <= 4'(i_r);
            state_r <= S_OUT;
          end
        end
        S_SHIFT_DN: begin
          if (CntW'(j_r) + CntW'(1) < held_r) begin
            times_r[j_r] <= times_r[j_r + IdxW'(1)];
            vals_r[j_r] <= vals_r[j_r + IdxW'(1)];
            j_r <= j_r + IdxW'(1);
          end else begin
            held_r <= held_r - CntW'(1);
            state_r <= S_OUT;
          end
        end
        S_EV_MUL: begin
          go_mul_r <= 1'b0;
          if (arsp.done) begin
            ga_r <= q64;
            gb_r <= {31'd0, max_time_r} + 64'd1;
            go_div_r <= 1'b1;
            state_r <= S_EV_MOD;
          end
        end
        S_EV_MOD: begin
          go_div_r <= 1'b0;
          if (arsp.done) begin
            // remainder is below max_time + 1 so it fits 32 bits
            t_r <= arsp.rem[31:0];
            i_r <= '0;
            state_r <= S_EV_FIND;
          end
        end
        S_EV_FIND: begin
          if (t_r >= times_r[last]) begin
            sv_r <= vals_r[last];
            state_r <= S_SCALE;
          end else if (ii != last && times_r[ii] < t_r) i_r <= i_r + CntW'(1);
          else if (times_r[ii] == t_r || i_r == '0) begin
            sv_r <= vals_r[ii];
            state_r <= S_SCALE;
          end else begin
            d_r <= dif;
            v1_r <= 33'(vals_r[ii - IdxW'(1)]);
            den_r <= times_r[ii] - times_r[ii - IdxW'(1)];
            ga_r <= {32'd0, t_r - times_r[ii - IdxW'(1)]};
            gb_r <= {32'd0, dif_mag};
            go_mul_r <= 1'b1;
            state_r <= S_EV_MUL2;
          end
        end
        S_EV_MUL2: begin
          go_mul_r <= 1'b0;
          if (arsp.done) begin
            ga_r <= arsp.res;
            gb_r <= {32'd0, den_r};
            go_div_r <= 1'b1;
            state_r <= S_EV_DIV;
          end
        end
        S_EV_DIV: begin
          go_div_r <= 1'b0;
          if (arsp.done) begin
            sv_r <= d_r[32] ? 32'(v1_r - 33'(arsp.res)) : 32'(v1_r + 33'(arsp.res));
            state_r <= S_SCALE;
          end
        end
        S_SCALE: begin
          ga_r <= {31'd0, mag33};
          gb_r <= {32'd0, value_scale_r};
          go_mul_r <= 1'b1;
          state_r <= S_SCALE_W;
        end
        S_SCALE_W: begin
          go_mul_r <= 1'b0;
          if (arsp.done) begin
            if (sv_r[31]) o_curve_r <= (q64 > 64'h8000_0000) ? 32'sh8000_0000
                                       : 32'(-q64);
            else o_curve_r <= (q64 > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : q64[31:0];
            state_r <= S_OUT;
          end
        end
        S_OUT: if (!out_stall) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: sim/kct_checker.sv
// kct_checker: watches the keyframe curve table channels, predicts each result
// from its own copy of the key table and registers, and counts mismatches
// depends on kct_pkg
`timescale 1ns / 1ps
module kct_checker
  import kct_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  in_operation,
  input  logic [31:0] in_time_req,
  input  logic [31:0] in_value,
  input  logic [3:0]  in_index,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_curve_value,
  input  logic [31:0] out_key_time_out,
  input  logic [31:0] out_key_value_out,
  input  logic [3:0]  out_key_position,
  input  logic [4:0]  out_key_count,
  input  logic [1:0]  out_status,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [31:0] curve;
    logic [31:0] ktime;
    logic [31:0] kval;
    logic [3:0]  pos;
    logic [4:0]  cnt;
    logic [1:0]  st;
  } key_result_t;

  // expected results in order, indexed by running write and read counts
  key_result_t exp_fifo [1024];
  int          wr_ptr;
  int          rd_ptr;

  logic [31:0]        span_max;
  logic [31:0]        repeat_mul;
  logic [31:0]        scale_mul;
  logic signed [31:0] clear_value;
  logic [31:0]        times_tbl [MaxKeys];
  logic signed [31:0] values_tbl [MaxKeys];
  int                 held;

  assign pending = wr_ptr - rd_ptr;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic logic signed [31:0] apply_scale(input logic signed [31:0] v);
    logic [63:0] mag;
    logic [63:0] q;
    mag = (v < 0) ? 64'(-(65'(v))) : 64'(v);
    q = (mag * 64'(scale_mul)) >> 16;
    if (v < 0) return (q > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-q);
    return (q > 64'h7fff_ffff) ? 32'sh7fff_ffff : 32'(q);
  endfunction

  function automatic logic signed [31:0] curve_at(input logic [31:0] treq);
    logic [31:0] t;
    logic [63:0] p;
    logic signed [63:0] v1, d;
    logic [63:0] dmag, q;
    int last, i;
    if (treq == 0 || held < 2) return apply_scale(values_tbl[0]);
    t = (treq < span_max) ? treq : span_max;
    p = (64'(t) * 64'(repeat_mul)) >> 16;
    t = 32'(p % (64'(span_max) + 64'd1));
    last = held - 1;
    if (t >= times_tbl[last]) return apply_scale(values_tbl[last]);
    for (i = 0; i < last; i++) if (times_tbl[i] >= t) break;
    if (times_tbl[i] == t || i == 0) return apply_scale(values_tbl[i]);
    v1 = values_tbl[i-1];
    d = 64'(values_tbl[i]) - v1;
    dmag = (d < 0) ? -d : d;
    q = (dmag * 64'(t - times_tbl[i-1])) / 64'(times_tbl[i] - times_tbl[i-1]);
    v1 = (d < 0) ? v1 - q : v1 + q;
    return apply_scale(v1[31:0]);
  endfunction

  function automatic key_result_t table_step(input op_t op, input logic [31:0] treq,
                                             input logic signed [31:0] val,
                                             input logic [3:0] idx);
    key_result_t r;
    int i, j;
    r = '0;
    r.st = ST_OK;
    case (op)
      OP_EVAL: r.curve = curve_at(treq);
      OP_ADD: begin
        if (treq > span_max) r.st = ST_TIME;
        else begin
          for (i = 0; i < held; i++) if (times_tbl[i] >= treq) break;
          if (i < held && times_tbl[i] == treq) begin
            values_tbl[i] = val;
            r.pos = 4'(i);
          end else if (held >= MaxKeys) r.st = ST_FULL;
          else begin
            for (j = held; j > i; j--) begin
              times_tbl[j] = times_tbl[j-1];
              values_tbl[j] = values_tbl[j-1];
            end
            times_tbl[i] = treq;
            values_tbl[i] = val;
            held++;
            r.pos = 4'(i);
          end
        end
      end
      OP_REMOVE: begin
        if (idx == 0 || idx >= held) r.st = ST_INDEX;
        else begin
          for (j = int'(idx); j + 1 < held; j++) begin
            times_tbl[j] = times_tbl[j+1];
            values_tbl[j] = values_tbl[j+1];
          end
          held--;
        end
      end
      OP_SETVAL: if (idx >= held) r.st = ST_INDEX; else values_tbl[idx] = val;
      OP_READ: begin
        if (idx >= held) r.st = ST_INDEX;
        else begin
          r.ktime = times_tbl[idx];
          r.kval = values_tbl[idx];
        end
      end
      OP_CLEAR, OP_SINGLE: begin
        times_tbl[0] = '0;
        values_tbl[0] = (op == OP_CLEAR) ? clear_value : val;
        held = 1;
      end
      default: ;
    endcase
    r.cnt = held[4:0];
    return r;
  endfunction

  always @(posedge clk) begin
    key_result_t want;
    if (!rst_n) begin
      span_max <= 32'd65536;
      repeat_mul <= 32'd65536;
      scale_mul <= 32'd65536;
      clear_value <= 32'sd65536;
      for (int k = 0; k < MaxKeys; k++) begin
        times_tbl[k] = '0;
        values_tbl[k] = '0;
      end
      values_tbl[0] = 32'sd65536;
      held = 1;
      wr_ptr = 0;
      rd_ptr = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_MAX_TIME:      span_max <= cfg_data;
          CFG_REPEAT_TIME:   repeat_mul <= cfg_data;
          CFG_VALUE_SCALE:   scale_mul <= cfg_data;
          CFG_DEFAULT_VALUE: clear_value <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        exp_fifo[wr_ptr[9:0]] = table_step(op_t'(in_operation), in_time_req,
                                           in_value, in_index);
        wr_ptr++;
      end
      if (out_valid && !out_stall) begin
        if (wr_ptr == rd_ptr) begin
          $display("%0t unexpected result beat", $realtime);
          fail_count++;
        end else begin
          want = exp_fifo[rd_ptr[9:0]];
          rd_ptr++;
          if (out_curve_value !== want.curve) report("curve_value", out_curve_value, want.curve);
          if (out_key_time_out !== want.ktime) report("key_time", out_key_time_out, want.ktime);
          if (out_key_value_out !== want.kval) report("key_value", out_key_value_out, want.kval);
          if (out_key_position !== want.pos) report("key_position", 32'(out_key_position), 32'(want.pos));
          if (out_key_count !== want.cnt) report("key_count", 32'(out_key_count), 32'(want.cnt));
          if (out_status !== want.st) report("status", 32'(out_status), 32'(want.st));
        end
      end
    end
  end

endmodule

// File: sim/tb.sv
// tb: stimulus and verdict for keyframe_curve_table_core
// depends on kct_pkg, keyframe_curve_table_core and kct_checker
`timescale 1ns / 1ps
module tb;
  import kct_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [2:0]  in_operation = '0;
  logic [31:0] in_time_req = '0;
  logic [31:0] in_value = '0;
  logic [3:0]  in_index = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [31:0] out_curve_value, out_key_time_out, out_key_value_out;
  logic [3:0]  out_key_position;
  logic [4:0]  out_key_count;
  logic [1:0]  out_status;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int          fail_count, pending;
  int          cycle_count = 0;
  int          hold_off = 0;
  bit          long_req = 0;
  bit          long_done = 0;
  int          long_left = 0;
  bit          calm = 0;
  logic [31:0] cur_span = 32'd65536;

  always #10 clk = ~clk;

  keyframe_curve_table_core dut (.*);
  kct_checker u_checker (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3_000_000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // one long receiver hold-off, counted here once requested
  always @(posedge clk) begin
    if (long_req && !long_done) begin
      long_left <= 400;
      long_done <= 1;
    end else if (long_left > 0) long_left <= long_left - 1;
  end

  // receiver stalls in bursts, or through the long hold-off
  always @(posedge clk) begin
    int burst;
    if (long_left > 0) out_stall <= 1;
    else if (hold_off > 0) begin
      out_stall <= 1;
      hold_off <= hold_off - 1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      burst = $urandom_range(1, 8);
      out_stall <= 1;
      hold_off <= burst - 1;
    end else out_stall <= 0;
  end

  task automatic cfg_write(input cfg_idx_t idx, input logic [31:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_MAX_TIME) cur_span = data;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic send_op(input op_t op, input logic [31:0] t, input logic [31:0] v,
                         input logic [3:0] idx);
    int gap;
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_operation <= op;
    in_time_req <= t;
    in_value <= v;
    in_index <= idx;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [31:0] pick_time();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return cur_span;
      2: return $urandom;
      3: return 32'($urandom_range(0, 8)) * (cur_span / 8);
      default: return (cur_span == 0) ? '0
                      : 32'(64'($urandom) % (64'(cur_span) + 64'd1));
    endcase
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 4))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_item();
    op_t op;
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) op = OP_EVAL;
    else if (r < 65) op = OP_ADD;
    else if (r < 75) op = OP_REMOVE;
    else if (r < 83) op = OP_SETVAL;
    else if (r < 93) op = OP_READ;
    else if (r < 96) op = OP_CLEAR;
    else if (r < 99) op = OP_SINGLE;
    else op = op_t'(3'd7);
    send_op(op, pick_time(), pick_value(), 4'($urandom));
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, every operation, error cases
    send_op(OP_EVAL, 0, 0, 0);
    send_op(OP_READ, 0, 0, 0);
    send_op(OP_READ, 0, 0, 4'hf);
    send_op(OP_REMOVE, 0, 0, 0);
    send_op(OP_ADD, 32'hffff_ffff, 1, 0);
    send_op(OP_ADD, 32'd32768, 32'h8000_0000, 0);
    send_op(OP_ADD, 32'd65536, 32'h7fff_ffff, 0);
    send_op(OP_ADD, 32'd32768, -32'sd5, 0);
    send_op(OP_EVAL, 32'd16384, 0, 0);
    send_op(OP_EVAL, 32'd32768, 0, 0);
    send_op(OP_EVAL, 32'hffff_ffff, 0, 0);
    send_op(OP_SETVAL, 0, 32'h1234_5678, 1);
    send_op(OP_SETVAL, 0, 0, 9);
    send_op(OP_REMOVE, 0, 0, 1);
    send_op(OP_REMOVE, 0, 0, 7);
    for (int k = 1; k < 17; k++) send_op(OP_ADD, 32'(k * 3000), $urandom, 0);
    send_op(OP_ADD, 3000, 32'hdead_beef, 0);
    send_op(op_t'(3'd7), 0, 0, 0);
    send_op(OP_CLEAR, 0, 0, 0);
    send_op(OP_SINGLE, 0, 32'h8000_0000, 0);
    drain();

    // random phases under different register settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin cfg_write(CFG_MAX_TIME, 32'hffff_ffff); cfg_write(CFG_REPEAT_TIME, 0); end
        1: begin cfg_write(CFG_REPEAT_TIME, 32'hffff_ffff); cfg_write(CFG_VALUE_SCALE, 0); end
        2: begin cfg_write(CFG_MAX_TIME, 1); cfg_write(CFG_VALUE_SCALE, 32'hffff_ffff); end
        3: begin cfg_write(CFG_DEFAULT_VALUE, 32'h8000_0000); cfg_write(CFG_MAX_TIME, 0); end
        default: begin
          cfg_write(CFG_MAX_TIME, $urandom_range(1, 32'h0010_0000));
          cfg_write(CFG_REPEAT_TIME, $urandom_range(0, 32'h0004_0000));
          cfg_write(CFG_VALUE_SCALE, $urandom_range(0, 32'h0003_0000));
          cfg_write(CFG_DEFAULT_VALUE, $urandom);
        end
      endcase
      cfg_valid <= 0;
      if (ph == 5) long_req <= 1;
      if (ph == 7) calm = 1;
      for (int n = 0; n < 115; n++) random_item();
      drain();
    end

    $display("covered %0d-cycle run: all seven operations plus an unused code,", cycle_count);
    $display("eight register settings with extreme values, full table and error paths");
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
